// ----- design/cct_pkg.sv -----
// cct_pkg: shared types and constants for the collision time unit.
// No dependencies.
package cct_pkg;

   typedef enum logic [1:0] {
      ST_TWO_TIMES   = 2'd0,
      ST_NO_HIT      = 2'd1,
      ST_STATIC_FAR  = 2'd2,
      ST_STATIC_OVER = 2'd3
   } status_type;

   localparam int TIME_BITS = 32;

endpackage

// ----- design/circle_collision_time_unit.sv -----
// circle_collision_time_unit: pipelined moving-circle collision time solver.
// Depends on cct_pkg, cct_sqrt_cell, cct_div_cell.
//
// Use: one transaction on req_ carries two circles (Q8.8 position, velocity,
// radius). One transaction on rsp_ returns status and two saturated times,
// earliest first, in order of the requests.
// Datapath: four front stages (relative motion, products, sums, discriminant),
// a chain of square-root cells (one result bit per cell), then two chains of
// divide cells (one quotient bit per cell) that run side by side, then an
// ordering stage.
// Throughput: one transaction per cycle while rsp_stall does not hold a result.
// The pipeline advances only while the output register is free or being
// taken; a result held by rsp_stall freezes every stage and raises req_stall.
// Reset clears the valid bits of all stages; no transaction is in flight.
module circle_collision_time_unit #(
   parameter int COORD_BITS = 16,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_BITS-1:0] req_pos_x_a,
   input  logic signed [COORD_BITS-1:0] req_pos_y_a,
   input  logic signed [COORD_BITS-1:0] req_vel_x_a,
   input  logic signed [COORD_BITS-1:0] req_vel_y_a,
   input  logic [COORD_BITS-2:0]      req_radius_a,
   input  logic signed [COORD_BITS-1:0] req_pos_x_b,
   input  logic signed [COORD_BITS-1:0] req_pos_y_b,
   input  logic signed [COORD_BITS-1:0] req_vel_x_b,
   input  logic signed [COORD_BITS-1:0] req_vel_y_b,
   input  logic [COORD_BITS-2:0]      req_radius_b,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic signed [31:0]         rsp_time_first,
   output logic signed [31:0]         rsp_time_second
);
   localparam int CW  = COORD_BITS + 1;        // relative coord
   localparam int PW2 = 2 * CW + 1;            // a, |b|, c magnitude
   localparam int DDW = 2 * PW2 + 2;           // discriminant width
   localparam int SQW = (DDW + 1) / 2;         // root width
   localparam int MW  = SQW + 1;               // qm width
   localparam int F   = TIME_FRAC_BITS;
   localparam int NW  = MW + F;                // dividend width
   localparam int QW  = NW;                    // quotient bits
   localparam int LAT = 4 + SQW + QW + 1;
   localparam int XW  = (NW > 33) ? NW : 33;   // saturation compare width

   logic adv;
   logic [LAT-1:0] v_ff;

   assign adv = !(v_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: relative motion
   logic signed [CW-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic [CW-1:0] rr_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= CW'(req_pos_x_a) - CW'(req_pos_x_b);
         py_ff <= CW'(req_pos_y_a) - CW'(req_pos_y_b);
         vx_ff <= CW'(req_vel_x_a) - CW'(req_vel_x_b);
         vy_ff <= CW'(req_vel_y_a) - CW'(req_vel_y_b);
         rr_ff <= CW'(req_radius_a) + CW'(req_radius_b);
      end
   end

   // stage 2: products
   logic signed [2*CW-1:0] pxvx_ff, pyvy_ff, pxvy_ff, pyvx_ff, vxx_ff, vyy_ff, pxx_ff, pyy_ff;
   logic [2*CW-1:0] rr2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pxvx_ff <= px_ff * vx_ff;
         pyvy_ff <= py_ff * vy_ff;
         pxvy_ff <= px_ff * vy_ff;
         pyvx_ff <= py_ff * vx_ff;
         vxx_ff  <= vx_ff * vx_ff;
         vyy_ff  <= vy_ff * vy_ff;
         pxx_ff  <= px_ff * px_ff;
         pyy_ff  <= py_ff * py_ff;
         rr2_ff  <= rr_ff * rr_ff;
      end
   end

   // stage 3: sums
   logic [PW2-1:0] a_ff;
   logic signed [PW2:0] b_ff, c_ff, cr_ff;
   logic [2*CW-1:0] rr2b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= PW2'($unsigned(vxx_ff)) + PW2'($unsigned(vyy_ff));
         b_ff    <= (PW2+1)'(pxvx_ff) + (PW2+1)'(pyvy_ff);
         c_ff    <= (PW2+1)'($unsigned(pxx_ff)) + (PW2+1)'($unsigned(pyy_ff))
                    - (PW2+1)'(rr2_ff);
         cr_ff   <= (PW2+1)'(pxvy_ff) - (PW2+1)'(pyvx_ff);
         rr2b_ff <= rr2_ff;
      end
   end

   // stage 4: discriminant
   logic [PW2-1:0] crm;
   assign crm = cr_ff[PW2] ? PW2'(-cr_ff) : PW2'(cr_ff);
   logic [DDW-1:0] lhs_ff, rhs_ff;
   logic [PW2-1:0] a4_ff;
   logic signed [PW2:0] b4_ff, c4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         lhs_ff <= DDW'(rr2b_ff) * DDW'(a_ff);
         rhs_ff <= DDW'(crm) * DDW'(crm);
         a4_ff  <= a_ff;
         b4_ff  <= b_ff;
         c4_ff  <= c_ff;
      end
   end

   // packed side data through the root chain
   localparam int SW = PW2 + 2 * (PW2 + 1) + 2;
   logic [SW-1:0] side0;
   logic [DDW-1:0] d0;
   logic neg_d;
   assign neg_d = lhs_ff < rhs_ff;
   assign d0 = neg_d ? '0 : DDW'(lhs_ff - rhs_ff);
   assign side0 = {a4_ff, b4_ff, c4_ff, neg_d, (a4_ff == '0)};

   logic [DDW-1:0] sd [SQW+1];
   logic [SQW-1:0] sr [SQW+1];
   logic [SW-1:0]  sp [SQW+1];
   assign sd[0] = d0;
   assign sr[0] = '0;
   assign sp[0] = side0;

   for (genvar g = 0; g < SQW; g++) begin : g_sqrt
      cct_sqrt_cell #(.DW(DDW), .RW(SQW), .PW(SW), .BIT(SQW-1-g)) u_cell (
         .clock(clock), .en(adv), .d_in(sd[g]), .r_in(sr[g]), .p_in(sp[g]),
         .d_out(sd[g+1]), .r_out(sr[g+1]), .p_out(sp[g+1])
      );
   end

   // divider setup
   logic [PW2-1:0] a_s;
   logic signed [PW2:0] b_s, c_s;
   logic nd_s, az_s;
   assign {a_s, b_s, c_s, nd_s, az_s} = sp[SQW];
   logic [PW2-1:0] bm_s, cm_s;
   assign bm_s = b_s[PW2] ? PW2'(-b_s) : PW2'(b_s);
   assign cm_s = c_s[PW2] ? PW2'(-c_s) : PW2'(c_s);
   logic [MW-1:0] qm_s;
   assign qm_s = MW'(bm_s) + MW'(sr[SQW]);
   logic qneg_s;
   assign qneg_s = !b_s[PW2];

   localparam int TW = 5;
   logic [TW-1:0] tag0;
   assign tag0 = {qneg_s, nd_s, az_s, (c_s > 0), (qm_s == '0)};

   logic [NW-1:0] n1 [QW+1], n2 [QW+1], q1 [QW+1], q2 [QW+1];
   logic [MW:0]   r1 [QW+1], r2 [QW+1];
   logic [MW-1:0] d1 [QW+1], d2 [QW+1];
   logic [TW-1:0] t1 [QW+1];
   logic          t2 [QW+1];
   assign n1[0] = NW'(qm_s) << F;
   assign n2[0] = NW'(cm_s) << F;
   assign d1[0] = MW'(a_s) | MW'(az_s);
   assign d2[0] = (qm_s == '0) ? MW'(1) : qm_s;
   assign r1[0] = '0;
   assign r2[0] = '0;
   assign q1[0] = '0;
   assign q2[0] = '0;
   assign t1[0] = tag0;
   assign t2[0] = (c_s[PW2] != qneg_s);

   for (genvar g = 0; g < QW; g++) begin : g_div
      cct_div_cell #(.NW(NW), .DW(MW), .PW(TW)) u_d1 (
         .clock(clock), .en(adv), .n_in(n1[g]), .rem_in(r1[g]), .den_in(d1[g]),
         .q_in(q1[g]), .p_in(t1[g]), .n_out(n1[g+1]), .rem_out(r1[g+1]),
         .den_out(d1[g+1]), .q_out(q1[g+1]), .p_out(t1[g+1])
      );
      cct_div_cell #(.NW(NW), .DW(MW), .PW(1)) u_d2 (
         .clock(clock), .en(adv), .n_in(n2[g]), .rem_in(r2[g]), .den_in(d2[g]),
         .q_in(q2[g]), .p_in(t2[g]), .n_out(n2[g+1]), .rem_out(r2[g+1]),
         .den_out(d2[g+1]), .q_out(q2[g+1]), .p_out(t2[g+1])
      );
   end

   function automatic logic signed [31:0] sat(input logic [NW-1:0] q, input logic neg);
      logic signed [31:0] r;
      logic [XW-1:0] qx;
      qx = XW'(q);
      if (neg) begin
         r = (qx > XW'(33'h080000000)) ? 32'sh80000000 : 32'(-qx);
      end else begin
         r = (qx > XW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(qx);
      end
      return r;
   endfunction

   logic [TW-1:0] tf;
   assign tf = t1[QW];
   logic signed [31:0] ta, tb;
   logic [1:0] st;
   always_comb begin
      ta = sat(q1[QW], tf[4]);
      tb = sat(q2[QW], t2[QW]);
      if (tf[2]) begin
         st = tf[1] ? cct_pkg::ST_STATIC_FAR : cct_pkg::ST_STATIC_OVER;
      end else if (tf[3]) begin
         st = cct_pkg::ST_NO_HIT;
      end else begin
         st = cct_pkg::ST_TWO_TIMES;
      end
      if (st != cct_pkg::ST_TWO_TIMES || tf[0]) begin
         ta = '0;
         tb = '0;
      end
   end

   logic [1:0] st_ff;
   logic signed [31:0] tf_ff, ts_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st;
         tf_ff <= (ta > tb) ? tb : ta;
         ts_ff <= (ta > tb) ? ta : tb;
      end
   end

   assign rsp_valid = v_ff[LAT-1];
   assign rsp_status = st_ff;
   assign rsp_time_first = tf_ff;
   assign rsp_time_second = ts_ff;

`ifndef SYNTHESIS
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_time_first <= rsp_time_second)
      else $error("times out of order");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cct_pkg::ST_TWO_TIMES
      |-> rsp_time_first == 0 && rsp_time_second == 0)
      else $error("times not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_time_first))
      else $error("stalled result moved");
`endif
endmodule

// ----- design/cct_sqrt_cell.sv -----
// cct_sqrt_cell: one restoring square-root step on the running remainder, registered.
// Depends on nothing; chained by circle_collision_time_unit.
module cct_sqrt_cell #(
   parameter int DW = 96,
   parameter int RW = 48,
   parameter int PW = 8,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] d_in,
   input  logic [RW-1:0] r_in,
   input  logic [PW-1:0] p_in,
   output logic [DW-1:0] d_out,
   output logic [RW-1:0] r_out,
   output logic [PW-1:0] p_out
);
   logic [DW-1:0]   trial;
   logic            fits;
   logic [RW-1:0]   r_ff;
   logic [DW-1:0]   d_ff;
   logic [PW-1:0]   p_ff;

   // d_in holds D - r^2; (r + 2^BIT)^2 - r^2 = r*2^(BIT+1) + 2^(2*BIT)
   always_comb begin
      trial = (DW'(r_in) << (BIT + 1)) + (DW'(1) << (2 * BIT));
      fits  = d_in >= trial;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= fits ? d_in - trial : d_in;
         p_ff <= p_in;
         r_ff <= fits ? (r_in | (RW'(1) << BIT)) : r_in;
      end
   end

   assign d_out = d_ff;
   assign r_out = r_ff;
   assign p_out = p_ff;
endmodule

// ----- design/cct_div_cell.sv -----
// cct_div_cell: one restoring division step on magnitudes, registered.
// Depends on nothing; chained by circle_collision_time_unit.
module cct_div_cell #(
   parameter int NW = 80,
   parameter int DW = 48,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] n_in,
   input  logic [DW:0]   rem_in,
   input  logic [DW-1:0] den_in,
   input  logic [NW-1:0] q_in,
   input  logic [PW-1:0] p_in,
   output logic [NW-1:0] n_out,
   output logic [DW:0]   rem_out,
   output logic [DW-1:0] den_out,
   output logic [NW-1:0] q_out,
   output logic [PW-1:0] p_out
);
   logic [DW+1:0] sh;
   logic          ge;
   logic [NW-1:0] n_ff, q_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] den_ff;
   logic [PW-1:0] p_ff;

   always_comb begin
      sh = {rem_in, n_in[NW-1]};
      ge = sh >= {2'b00, den_in};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in << 1;
         den_ff <= den_in;
         p_ff   <= p_in;
         q_ff   <= {q_in[NW-2:0], ge};
         rem_ff <= ge ? (DW+1)'(sh - {2'b00, den_in}) : sh[DW:0];
      end
   end

   assign n_out = n_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign q_out = q_ff;
   assign p_out = p_ff;
endmodule
